### hdl/pbrt_pkg.sv
// Shared types and codes for the packet block rule table.
package pbrt_pkg;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CHECK  = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [13:0] TICKS_PER_MS = 14'd10000;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] now_time;
    logic [7:0]  ip_ver;
    logic [7:0]  protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;
    logic [31:0] lifetime_ms;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       block;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the request beat
    logic eval;    // compare all slots and update the table
  } cmd_t;

endpackage

### hdl/pbrt_if.sv
// Valid/ready channel interfaces for requests and results.
interface pbrt_req_if;
  logic            valid;
  logic            ready;
  pbrt_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pbrt_rsp_if;
  logic            valid;
  logic            ready;
  pbrt_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/packet_block_rule_table.sv
// Top level of the packet block rule table.
// The accepted request beat is registered, the evaluate state compares all
// slots and updates the table, and the registered result is held until taken;
// a new request is taken while idle or as the previous result is taken.
// Reset: synchronous active-low rst_n clears all slot live bits and the
// controller; rule fields need no reset.
module packet_block_rule_table #(
  parameter int RULE_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pbrt_req_if.sink   in_ch,
  pbrt_rsp_if.source out_ch
);
  pbrt_pkg::cmd_t cmd;

  // sequencer: owns the handshakes on both channels
  pbrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // table, compare array and result register
  pbrt_dp #(.RULE_SLOTS(RULE_SLOTS)) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .req   (in_ch.data),
    .rsp   (out_ch.data)
  );
endmodule

### hdl/pbrt_ctrl.sv
// Controller: load, evaluate, present result.
module pbrt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output pbrt_pkg::cmd_t   cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // take a new beat whenever nothing is in flight or the result leaves now
  assign in_ready  = (state_r == S_IDLE) || (state_r == S_OUT && out_ready);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.eval  = (state_r == S_EVAL);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) state_nxt = in_valid ? S_EVAL : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

### hdl/pbrt_dp.sv
// Datapath: rule storage, parallel slot compare, priority pick, update.
module pbrt_dp #(
  parameter int RULE_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pbrt_pkg::cmd_t  cmd,
  input  pbrt_pkg::req_t  req,
  output pbrt_pkg::rsp_t  rsp
);
  localparam logic [RULE_SLOTS-1:0] SLOT_ONE = RULE_SLOTS'(1);

  pbrt_pkg::req_t            req_r;
  logic [RULE_SLOTS-1:0]     live_r, live_nxt;
  logic [7:0]                ipv_r   [RULE_SLOTS];
  logic [7:0]                proto_r [RULE_SLOTS];
  logic [15:0]               sport_r [RULE_SLOTS];
  logic [15:0]               dport_r [RULE_SLOTS];
  logic [63:0]               sah_r   [RULE_SLOTS];
  logic [63:0]               sal_r   [RULE_SLOTS];
  logic [63:0]               dah_r   [RULE_SLOTS];
  logic [63:0]               dal_r   [RULE_SLOTS];
  logic [63:0]               slot_limit_r [RULE_SLOTS];  // added time plus lifetime ticks
  logic [63:0]               new_limit_r;
  logic [45:0]               life_ticks;
  logic [RULE_SLOTS-1:0]     expired, hit, freev, keyv;
  logic [RULE_SLOTS-1:0]     free_sel, hit_sel, key_sel, retire;
  pbrt_pkg::rsp_t            rsp_r, rsp_nxt;

  // expiry limit computed at write time: one 32x14 multiply plus one add
  assign life_ticks = 46'(req.lifetime_ms) * 46'(pbrt_pkg::TICKS_PER_MS);

  assign rsp = rsp_r;

  always_comb begin
    for (int s = 0; s < RULE_SLOTS; s++) begin
      expired[s] = req_r.now_time > slot_limit_r[s];
      freev[s]   = !live_r[s] || expired[s];
      keyv[s]    = live_r[s] && (dport_r[s] == req_r.dest_port);
      hit[s] = live_r[s] && !expired[s]
        && (ipv_r[s] == '0 || ipv_r[s] == req_r.ip_ver)
        && (proto_r[s] == '0 || proto_r[s] == req_r.protocol)
        && (sport_r[s] == '0 || sport_r[s] == req_r.source_port)
        && (dport_r[s] == '0 || dport_r[s] == req_r.dest_port)
        && ((sah_r[s] == '0 && sal_r[s] == '0)
            || (sah_r[s] == req_r.source_addr_high && sal_r[s] == req_r.source_addr_low))
        && ((dah_r[s] == '0 && dal_r[s] == '0)
            || (dah_r[s] == req_r.dest_addr_high && dal_r[s] == req_r.dest_addr_low));
    end
    // lowest-set pick: x & -x
    free_sel = freev & (~freev + SLOT_ONE);
    hit_sel  = hit & (~hit + SLOT_ONE);
    key_sel  = keyv & (~keyv + SLOT_ONE);
    // expired slots below the first hit, or all when nothing hits
    retire   = live_r & expired & (hit_sel - SLOT_ONE);
    if (hit == '0) retire = live_r & expired;

    live_nxt = live_r;
    rsp_nxt  = '{status: pbrt_pkg::ST_INVALID, block: 1'b0};
    case (req_r.action)
      pbrt_pkg::ACT_ADD: begin
        live_nxt = live_r | free_sel;
        rsp_nxt.status = (freev != '0) ? pbrt_pkg::ST_OK : pbrt_pkg::ST_FULL;
      end
      pbrt_pkg::ACT_CHECK: begin
        live_nxt = live_r & ~retire;
        rsp_nxt.status = pbrt_pkg::ST_OK;
        rsp_nxt.block  = (hit != '0);
      end
      pbrt_pkg::ACT_REMOVE: begin
        if (req_r.dest_port != '0) begin
          live_nxt = live_r & ~key_sel;
          rsp_nxt.status = (keyv != '0) ? pbrt_pkg::ST_OK : pbrt_pkg::ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r       <= req;
      new_limit_r <= req.now_time + 64'(life_ticks);
    end
    if (cmd.eval) begin
      rsp_r <= rsp_nxt;
      if (req_r.action == pbrt_pkg::ACT_ADD) begin
        for (int s = 0; s < RULE_SLOTS; s++) begin
          if (free_sel[s]) begin
            ipv_r[s]        <= req_r.ip_ver;
            proto_r[s]      <= req_r.protocol;
            sport_r[s]      <= req_r.source_port;
            dport_r[s]      <= req_r.dest_port;
            sah_r[s]        <= req_r.source_addr_high;
            sal_r[s]        <= req_r.source_addr_low;
            dah_r[s]        <= req_r.dest_addr_high;
            dal_r[s]        <= req_r.dest_addr_low;
            slot_limit_r[s] <= new_limit_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        live_r <= '0;
    else if (cmd.eval) live_r <= live_nxt;
  end
endmodule

### hdl/pbrt_checker.sv
// Port-level checker for the rule table, bound to the top level.
module pbrt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input pbrt_pkg::rsp_t out_data
);
  // a result only follows an accepted beat
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2)) else $error("unexpected result");
  // block is only reported with success
  a_block_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.block |-> out_data.status == pbrt_pkg::ST_OK)
    else $error("block with bad status");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  // accepted beat gives a result after the evaluate state
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid) else $error("latency");
endmodule

bind packet_block_rule_table pbrt_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
